/* rtl/core/slip_pkg.sv */
`timescale 1ns / 1ps
package slip_pkg;

	localparam int RAW_W           = 10;
	localparam logic [RAW_W-1:0] RAW_LIMIT_RESET = 10'd130;

	localparam int MAX_PACKET_BYTES_DEF = 64;
	localparam int LEN_W                = 7;

	// depth of the queue between front and back, a power of two
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] BYTE_END     = 8'hC0;
	localparam logic [7:0] BYTE_ESC     = 8'hDB;
	localparam logic [7:0] BYTE_ESC_END = 8'hDC;
	localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

	// one classified raw word handed from front to back
	typedef struct packed {
		logic       is_end;
		logic [7:0] raw;
	} tok_t;

endpackage

/* rtl/core/slip_front.sv */
`timescale 1ns / 1ps
module slip_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [slip_pkg::RAW_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 rx_byte,
	output logic                       push,
	output slip_pkg::tok_t             push_tok,
	input  logic                       q_full
);
	import slip_pkg::*;

	logic [RAW_W-1:0] raw_limit_q;
	logic [RAW_W-1:0] raw_count_q;
	logic             accept;
	logic             is_end;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_end   = (rx_byte == BYTE_END);

	// empty frames and words past the raw limit never reach the back
	always_comb begin
		push = 1'b0;
		if (accept) begin
			if (is_end)
				push = (raw_count_q != '0);
			else
				push = (raw_count_q < raw_limit_q);
		end
	end

	assign push_tok.is_end = is_end;
	assign push_tok.raw    = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_limit_q <= RAW_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			raw_limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_count_q <= '0;
		end else if (accept) begin
			if (is_end)
				raw_count_q <= '0;
			else if (raw_count_q < raw_limit_q)
				raw_count_q <= raw_count_q + RAW_W'(1);
		end
	end

endmodule

/* rtl/core/slip_queue.sv */
`timescale 1ns / 1ps
module slip_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  slip_pkg::tok_t push_tok,
	output logic           full,
	output logic           q_valid,
	output slip_pkg::tok_t q_tok,
	input  logic           pop
);
	import slip_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tok_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_tok   = mem_q[rd_ptr_q];
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

/* rtl/core/slip_back.sv */
`timescale 1ns / 1ps
module slip_back #(
	parameter int MAX_PACKET_BYTES = slip_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  slip_pkg::tok_t             q_tok,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       is_frame_end,
	output logic [7:0]                 data_byte,
	output logic                       frame_good,
	output logic [slip_pkg::LEN_W-1:0] decoded_length
);
	import slip_pkg::*;

	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);

	logic [CNT_W-1:0] dcount_q;
	logic [7:0]       first_q;
	logic             prev_esc_q;
	logic             stopped_q;
	logic             out_valid_q;

	logic [CNT_W-1:0] dcount_d;
	logic [7:0]       first_d;
	logic             prev_esc_d;
	logic             stopped_d;
	logic             emit;
	logic             have;
	logic [7:0]       dec;
	logic             good;
	logic [CNT_W+LEN_W-1:0] len_ext;

	assign pop       = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign len_ext   = {{LEN_W{1'b0}}, dcount_q};
	assign good      = (dcount_q != '0) && (10'(dcount_q) == 10'(first_q) + 10'd1);

	always_comb begin
		dcount_d   = dcount_q;
		first_d    = first_q;
		prev_esc_d = prev_esc_q;
		stopped_d  = stopped_q;
		emit       = 1'b0;
		have       = 1'b0;
		dec        = '0;
		if (q_tok.is_end) begin
			emit       = 1'b1;
			dcount_d   = '0;
			first_d    = '0;
			prev_esc_d = 1'b0;
			stopped_d  = 1'b0;
		end else if (!stopped_q && dcount_q < CNT_W'(MAX_PACKET_BYTES)) begin
			if (!prev_esc_q) begin
				prev_esc_d = (q_tok.raw == BYTE_ESC);
				have       = (q_tok.raw != BYTE_ESC);
				dec        = q_tok.raw;
			end else if (q_tok.raw == BYTE_ESC_END) begin
				prev_esc_d = 1'b0;
				have       = 1'b1;
				dec        = BYTE_END;
			end else if (q_tok.raw == BYTE_ESC_ESC) begin
				prev_esc_d = 1'b0;
				have       = 1'b1;
				dec        = BYTE_ESC;
			end else begin
				// unknown escape, hold off until the next end
				stopped_d = 1'b1;
			end
			if (have) begin
				emit     = 1'b1;
				dcount_d = dcount_q + CNT_W'(1);
				if (dcount_q == '0)
					first_d = dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcount_q   <= '0;
			first_q    <= '0;
			prev_esc_q <= 1'b0;
			stopped_q  <= 1'b0;
		end else if (pop) begin
			dcount_q   <= dcount_d;
			first_q    <= first_d;
			prev_esc_q <= prev_esc_d;
			stopped_q  <= stopped_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			is_frame_end   <= q_tok.is_end;
			data_byte      <= q_tok.is_end ? 8'h00 : dec;
			frame_good     <= q_tok.is_end ? good : 1'b0;
			decoded_length <= q_tok.is_end ? len_ext[LEN_W-1:0] : '0;
		end
	end

endmodule

/* rtl/core/slip_frame_receiver_length_check.sv */
`timescale 1ns / 1ps
// slip frame receiver with length check
// input channel: in_valid / in_stall carry one raw serial word (rx_byte) per cycle.
// output channel: out_valid / out_stall carry either a decoded data word
//   (is_frame_end = 0, data_byte) or an end-of-frame verdict word
//   (is_frame_end = 1, frame_good, decoded_length); the consumer drops bad frames.
// cfg_wr_en / cfg_wr_data write the raw word limit per frame; write it only when idle.
// throughput: one raw word per cycle while out_stall is low, set by the front
//   taking one word and the back decoding one word each cycle.
// path: a taken raw word is written into the front-to-back queue, and its result
//   is then registered into the output register, where it can be taken.
// escapes and words after a bad escape or a full packet still pass through the
//   queue and are popped by the back; words past the raw limit and ends of empty
//   frames are dropped in the front.
// when out_stall is held and a word is in the output register, the register holds,
//   the back stops, the queue fills and in_stall rises once it is full.
// reset empties the queue, clears the output valid flag and all frame state, and sets the
//   raw word limit to 130.
module slip_frame_receiver_length_check #(
	parameter int MAX_PACKET_BYTES = slip_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [slip_pkg::RAW_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 rx_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       is_frame_end,
	output logic [7:0]                 data_byte,
	output logic                       frame_good,
	output logic [slip_pkg::LEN_W-1:0] decoded_length
);
	import slip_pkg::*;

	logic push;
	tok_t push_tok;
	logic q_full;
	logic q_valid;
	tok_t q_tok;
	logic pop;

	slip_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.push        (push),
		.push_tok    (push_tok),
		.q_full      (q_full)
	);

	slip_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_tok    (q_tok),
		.pop      (pop)
	);

	slip_back #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_tok          (q_tok),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.is_frame_end   (is_frame_end),
		.data_byte      (data_byte),
		.frame_good     (frame_good),
		.decoded_length (decoded_length)
	);

endmodule

/* verif/slip_frame_receiver_length_check_test.sv */
`timescale 1ns / 1ps
module slip_frame_receiver_length_check_test;
	import slip_pkg::*;

	localparam int PKT_MAX     = MAX_PACKET_BYTES_DEF;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 6;
	localparam int HOLD_AFTER  = 150;
	localparam int HOLD_CYCLES = 300;

	typedef logic [7:0] raw_q_t[$];

	typedef struct {
		logic             is_end;
		logic [7:0]       data;
		logic             good;
		logic [LEN_W-1:0] len;
	} rx_word_t;

	// tracks frame state and the decoded words still owed by the block
	class slip_decode_tracker;
		rx_word_t         expected_words[$];
		logic [RAW_W-1:0] raw_limit = RAW_LIMIT_RESET;
		int               raw_cnt = 0;
		int               dec_cnt = 0;
		int               first_dec = 0;
		logic [7:0]       prev_raw = 8'h00;
		bit               stopped = 1'b0;
		int               mismatches = 0;
		int               checked = 0;

		function int pending();
			return expected_words.size();
		endfunction

		function void take_raw(logic [7:0] b);
			rx_word_t   w;
			logic [7:0] dec;
			bit         have;
			have = 1'b0;
			dec = 8'h00;
			if (b == BYTE_END) begin
				if (raw_cnt == 0)
					return;
				w.is_end = 1'b1;
				w.data = 8'h00;
				w.good = (dec_cnt != 0 && dec_cnt == first_dec + 1);
				w.len = dec_cnt[LEN_W-1:0];
				expected_words.push_back(w);
				raw_cnt = 0;
				dec_cnt = 0;
				first_dec = 0;
				prev_raw = 8'h00;
				stopped = 1'b0;
				return;
			end
			if (raw_cnt >= raw_limit)
				return;
			raw_cnt++;
			if (stopped || dec_cnt >= PKT_MAX)
				return;
			if (prev_raw != BYTE_ESC) begin
				if (b != BYTE_ESC) begin
					dec = b;
					have = 1'b1;
				end
			end else if (b == BYTE_ESC_END) begin
				dec = BYTE_END;
				have = 1'b1;
			end else if (b == BYTE_ESC_ESC) begin
				dec = BYTE_ESC;
				have = 1'b1;
			end else begin
				// bad escape: nothing decoded until the next end
				stopped = 1'b1;
				return;
			end
			prev_raw = b;
			if (!have)
				return;
			if (dec_cnt == 0)
				first_dec = dec;
			dec_cnt++;
			w.is_end = 1'b0;
			w.data = dec;
			w.good = 1'b0;
			w.len = '0;
			expected_words.push_back(w);
		endfunction

		function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s expected %0h actual %0h", name, exp_v, act_v);
				mismatches++;
			end
		endfunction

		function void check_word(logic e, logic [7:0] d, logic g, logic [LEN_W-1:0] l);
			rx_word_t w;
			checked++;
			if (expected_words.size() == 0) begin
				$error("unexpected word: is_frame_end %0h data_byte %0h", e, d);
				mismatches++;
				return;
			end
			w = expected_words.pop_front();
			cmp_field("is_frame_end", 8'(w.is_end), 8'(e));
			cmp_field("data_byte", w.data, d);
			cmp_field("frame_good", 8'(w.good), 8'(g));
			cmp_field("decoded_length", 8'(w.len), 8'(l));
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [RAW_W-1:0] cfg_wr_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       rx_byte = 8'h00;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             is_frame_end;
	logic [7:0]       data_byte;
	logic             frame_good;
	logic [LEN_W-1:0] decoded_length;

	slip_decode_tracker tracker;
	int words_sent = 0;
	int send_calm_left = 0;
	int stall_left = 0;
	int out_calm_left = 0;
	bit long_hold_done = 1'b0;
	int quiet_cycles = 0;

	slip_frame_receiver_length_check dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.is_frame_end  (is_frame_end),
		.data_byte     (data_byte),
		.frame_good    (frame_good),
		.decoded_length(decoded_length)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly short idles, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [7:0] any_byte();
		if ($urandom_range(0, 99) >= 15)
			return 8'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0: return BYTE_END;
			1: return BYTE_ESC;
			2: return BYTE_ESC_END;
			default: return BYTE_ESC_ESC;
		endcase
	endfunction

	task automatic send_raw(input logic [7:0] b);
		int gap;
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_raw(b);
		words_sent++;
		if (send_calm_left > 0) begin
			send_calm_left--;
			gap = 0;
		end else begin
			gap = idle_len();
			if (gap == 0 && $urandom_range(0, 99) < 3)
				send_calm_left = $urandom_range(30, 150);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_frame();
		raw_q_t body;
		raw_q_t raw;
		int     n;
		int     kind;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			// line noise with no framing of its own
			n = $urandom_range(1, 20);
			repeat (n) send_raw(any_byte());
			return;
		end
		n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(50, 80);
		for (int i = 0; i < n; i++)
			body.push_back(any_byte());
		if ($urandom_range(0, 99) < 70)
			body[0] = 8'(n - 1);
		foreach (body[i]) begin
			if (body[i] == BYTE_END) begin
				raw.push_back(BYTE_ESC);
				raw.push_back(BYTE_ESC_END);
			end else if (body[i] == BYTE_ESC) begin
				raw.push_back(BYTE_ESC);
				raw.push_back(BYTE_ESC_ESC);
			end else begin
				raw.push_back(body[i]);
			end
		end
		// broken frame: a stray escape somewhere inside
		if (kind < 24)
			raw.insert($urandom_range(0, raw.size()), BYTE_ESC);
		raw.push_back(BYTE_END);
		foreach (raw[i])
			send_raw(raw[i]);
	endtask

	task automatic write_raw_limit(input logic [RAW_W-1:0] v);
		int calm;
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		// words with no result may still be in flight
		calm = 0;
		while (calm < DRAIN_WAIT) begin
			@(posedge clk);
			if (!out_stall)
				calm++;
		end
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.raw_limit = v;
	endtask

	initial begin
		raw_q_t directed;
		int     limits[7];
		int     phase_end[7];
		tracker = new();
		directed = '{BYTE_END,
			8'h02, 8'h00, 8'hFF, BYTE_END,
			8'h00, BYTE_END,
			BYTE_ESC, BYTE_ESC_END, BYTE_ESC, BYTE_ESC_ESC, 8'h01, BYTE_END,
			BYTE_ESC, BYTE_END,
			8'h05, BYTE_ESC, 8'h55, 8'h11, BYTE_END,
			BYTE_ESC, BYTE_ESC, 8'h22, BYTE_END};
		limits = '{130, 1, 1023, 0, 0, 3, 130};
		limits[4] = $urandom_range(2, 1022);
		phase_end = '{400, 550, 950, 1010, 1350, 1500, 1720};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_raw(directed[i]);
		for (int p = 0; p < 7; p++) begin
			if (p > 0)
				write_raw_limit(RAW_W'(limits[p]));
			while (words_sent < phase_end[p])
				send_random_frame();
		end
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("PASS slip_frame_receiver_length_check");
		else
			$display("FAIL slip_frame_receiver_length_check");
		$finish;
	end

	// result side: check each taken word, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.check_word(is_frame_end, data_byte, frame_good, decoded_length);
			if (!long_hold_done && tracker.checked >= HOLD_AFTER) begin
				// long hold-off so the block backs up into its input
				long_hold_done = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0) begin
				if (out_calm_left > 0) begin
					out_calm_left--;
				end else begin
					stall_left = idle_len();
					if (stall_left == 0 && $urandom_range(0, 99) < 3)
						out_calm_left = $urandom_range(30, 150);
				end
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL slip_frame_receiver_length_check");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
